@@ hw/rtl/ucd_pkg.sv @@
package ucd_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_DETACH   = 3'd1,
    OP_VBUS     = 3'd2,
    OP_ENUM     = 3'd3,
    OP_SUSPEND  = 3'd4,
    OP_RESUME   = 3'd5,
    OP_SAMPLE   = 3'd6,
    OP_MAINS    = 3'd7
  } op_e;

  localparam logic [1:0] KIND_SDP = 2'd0;
  localparam logic [1:0] KIND_CDP = 2'd1;
  localparam logic [1:0] KIND_DCP = 2'd2;

  localparam logic [1:0] CODE_NONE   = 2'd0;
  localparam logic [1:0] CODE_100MA  = 2'd1;
  localparam logic [1:0] CODE_500MA  = 2'd2;
  localparam logic [1:0] LINE_DCP    = 2'd3;
  localparam logic [7:0] STS_INVALID = 8'haa;
  localparam int unsigned STS_BATT_BIT  = 4;
  localparam int unsigned STS_MAINS_BIT = 3;
  localparam int unsigned STS_USB_BIT   = 2;

  localparam logic [9:0] LIMIT_500MA = 10'd500;
  localparam logic [9:0] LIMIT_100MA = 10'd100;

  localparam int unsigned TMO_W   = 12;
  localparam int unsigned MA_W    = 10;
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;

  localparam logic [2:0] REG_DCD_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_POLL_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_CDP_ENUM     = 3'd2;
  localparam logic [2:0] REG_CDP_SUSPEND  = 3'd3;
  localparam logic [2:0] REG_SDP_SUSPEND  = 3'd4;

  localparam logic [TMO_W-1:0] RST_DCD_TIMEOUT  = 12'd3000;
  localparam logic [TMO_W-1:0] RST_POLL_TIMEOUT = 12'd300;
  localparam logic [MA_W-1:0]  RST_CDP_ENUM     = 10'd900;
  localparam logic [MA_W-1:0]  RST_CDP_SUSPEND  = 10'd500;
  localparam logic [MA_W-1:0]  RST_SDP_SUSPEND  = 10'd2;

  typedef struct packed {
    logic [TMO_W-1:0] dcd_timeout_ms;
    logic [TMO_W-1:0] poll_timeout_ms;
    logic [MA_W-1:0]  cdp_enum_ma;
    logic [MA_W-1:0]  cdp_suspend_ma;
    logic [MA_W-1:0]  sdp_suspend_ma;
  } cfg_t;

  typedef struct packed {
    logic [2:0]      op;
    logic [MA_W-1:0] event_ma;
    logic [7:0]      status_byte;
    logic            read_ok;
    logic            dp_low;
    logic [1:0]      line_state;
  } in_word_t;

  typedef struct packed {
    logic            usb_supply_ok;
    logic [MA_W-1:0] usb_limit_ma;
    logic [1:0]      port_kind;
    logic            mains_present;
    logic            contact_ok;
    logic            busy_res;
    logic            detect_done;
    logic            try_connect;
  } out_word_t;

endpackage

@@ hw/rtl/ucd_if.sv @@
interface ucd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [9:0] event_ma;
  logic [7:0] status_byte;
  logic       read_ok;
  logic       dp_low;
  logic [1:0] line_state;

  modport source (output valid, op, event_ma, status_byte, read_ok, dp_low, line_state,
                  input ready);
  modport sink (input valid, op, event_ma, status_byte, read_ok, dp_low, line_state,
                output ready);
endinterface

interface ucd_out_if;
  logic       valid;
  logic       ready;
  logic       usb_supply_ok;
  logic [9:0] usb_limit_ma;
  logic [1:0] port_kind;
  logic       mains_present;
  logic       contact_ok;
  logic       busy_res;
  logic       detect_done;
  logic       try_connect;

  modport source (output valid, usb_supply_ok, usb_limit_ma, port_kind, mains_present,
                  contact_ok, busy_res, detect_done, try_connect,
                  input ready);
  modport sink (input valid, usb_supply_ok, usb_limit_ma, port_kind, mains_present,
                contact_ok, busy_res, detect_done, try_connect,
                output ready);
endinterface

@@ hw/rtl/ucd_cfg.sv @@
module ucd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [ucd_pkg::APB_AW-1:0]  paddr_i,
  input  logic [ucd_pkg::APB_DW-1:0]  pwdata_i,
  output logic [ucd_pkg::APB_DW-1:0]  prdata_o,
  output logic                        pready_o,
  output ucd_pkg::cfg_t               cfg_o
);
  import ucd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[APB_AW-1:2];
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DCD_TIMEOUT:  cfg_d.dcd_timeout_ms  = pwdata_i[TMO_W-1:0];
        REG_POLL_TIMEOUT: cfg_d.poll_timeout_ms = pwdata_i[TMO_W-1:0];
        REG_CDP_ENUM:     cfg_d.cdp_enum_ma     = pwdata_i[MA_W-1:0];
        REG_CDP_SUSPEND:  cfg_d.cdp_suspend_ma  = pwdata_i[MA_W-1:0];
        REG_SDP_SUSPEND:  cfg_d.sdp_suspend_ma  = pwdata_i[MA_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DCD_TIMEOUT:  prdata_o = {{(APB_DW-TMO_W){1'b0}}, cfg_q.dcd_timeout_ms};
      REG_POLL_TIMEOUT: prdata_o = {{(APB_DW-TMO_W){1'b0}}, cfg_q.poll_timeout_ms};
      REG_CDP_ENUM:     prdata_o = {{(APB_DW-MA_W){1'b0}}, cfg_q.cdp_enum_ma};
      REG_CDP_SUSPEND:  prdata_o = {{(APB_DW-MA_W){1'b0}}, cfg_q.cdp_suspend_ma};
      REG_SDP_SUSPEND:  prdata_o = {{(APB_DW-MA_W){1'b0}}, cfg_q.sdp_suspend_ma};
      default:          prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dcd_timeout_ms  <= RST_DCD_TIMEOUT;
      cfg_q.poll_timeout_ms <= RST_POLL_TIMEOUT;
      cfg_q.cdp_enum_ma     <= RST_CDP_ENUM;
      cfg_q.cdp_suspend_ma  <= RST_CDP_SUSPEND;
      cfg_q.sdp_suspend_ma  <= RST_SDP_SUSPEND;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/ucd_core.sv @@
module ucd_core #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                commit_i,
  input  ucd_pkg::in_word_t   word_i,
  input  ucd_pkg::cfg_t       cfg_i,
  output ucd_pkg::out_word_t  word_o
);
  import ucd_pkg::*;

  localparam int unsigned CW = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;
  localparam logic [TIMER_BITS-1:0] TMR_MAX = '1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DCD  = 2'd1,
    PH_POLL = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic [1:0]            code_q, code_d;
  logic                  contact_q, contact_d;
  logic                  present_q, present_d;
  logic [MA_W-1:0]       limit_q, limit_d;
  logic [1:0]            kind_q, kind_d;
  logic                  mains_q, mains_d;
  out_word_t             out_q, out_d;

  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [TMO_W-1:0]      tmo_sel;
  logic                  expired;
  logic                  busy;
  logic                  done;
  logic                  sts_good;
  logic                  classify;
  logic [1:0]            code_use;

  assign busy        = (phase_q == PH_DCD) || (phase_q == PH_POLL);
  assign elapsed_inc = (elapsed_q != TMR_MAX) ? elapsed_q + 1'b1 : elapsed_q;
  assign tmo_sel     = (phase_q == PH_DCD) ? cfg_i.dcd_timeout_ms : cfg_i.poll_timeout_ms;
  assign expired     = (CW'(elapsed_inc) > CW'(tmo_sel)) || (elapsed_inc == TMR_MAX);
  assign sts_good    = word_i.read_ok && (word_i.status_byte != STS_INVALID) &&
                       word_i.status_byte[STS_BATT_BIT] && word_i.status_byte[STS_USB_BIT];

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    code_d    = code_q;
    contact_d = contact_q;
    present_d = present_q;
    limit_d   = limit_q;
    kind_d    = kind_q;
    mains_d   = mains_q;
    done      = 1'b0;
    classify  = 1'b0;
    code_use  = code_q;

    case (op_e'(word_i.op))
      OP_TICK: begin
        if (phase_q == PH_DCD) begin
          elapsed_d = elapsed_inc;
          if (expired) begin
            contact_d = 1'b0;
            phase_d   = PH_POLL;
            elapsed_d = '0;
          end
        end else if (phase_q == PH_POLL) begin
          elapsed_d = elapsed_inc;
          classify  = expired;
        end
      end
      OP_DETACH: begin
        phase_d   = PH_IDLE;
        elapsed_d = '0;
        present_d = 1'b0;
        limit_d   = '0;
        contact_d = 1'b0;
        kind_d    = KIND_SDP;
      end
      OP_VBUS: begin
        if (!busy) begin
          phase_d   = PH_DCD;
          elapsed_d = '0;
          code_d    = CODE_NONE;
          contact_d = 1'b0;
        end
      end
      OP_ENUM: begin
        if (!busy && (word_i.event_ma != '0)) begin
          present_d = 1'b1;
          limit_d   = (kind_q == KIND_CDP) ? cfg_i.cdp_enum_ma : word_i.event_ma;
        end
      end
      OP_SUSPEND: begin
        if (!busy) begin
          present_d = 1'b1;
          limit_d   = (kind_q == KIND_CDP) ? cfg_i.cdp_suspend_ma : cfg_i.sdp_suspend_ma;
        end
      end
      OP_RESUME: begin
        if (!busy) begin
          present_d = 1'b1;
          limit_d   = (kind_q == KIND_CDP) ? cfg_i.cdp_suspend_ma : word_i.event_ma;
        end
      end
      OP_SAMPLE: begin
        if (phase_q == PH_DCD) begin
          if (!word_i.read_ok || word_i.dp_low) begin
            contact_d = word_i.read_ok;
            phase_d   = PH_POLL;
            elapsed_d = '0;
          end
        end else if (phase_q == PH_POLL) begin
          code_use = sts_good ? word_i.status_byte[1:0] : CODE_NONE;
          code_d   = code_use;
          classify = (code_use == CODE_500MA) || !contact_q;
        end
      end
      OP_MAINS: begin
        mains_d = word_i.read_ok && (word_i.status_byte != STS_INVALID) &&
                  word_i.status_byte[STS_MAINS_BIT];
      end
      default: begin
        mains_d = mains_q;
      end
    endcase

    if (classify) begin
      done      = 1'b1;
      phase_d   = PH_IDLE;
      elapsed_d = '0;
      if (code_use == CODE_500MA) begin
        present_d = 1'b1;
        limit_d   = LIMIT_500MA;
        kind_d    = (word_i.line_state != LINE_DCP) ? KIND_CDP : KIND_DCP;
      end else if (code_use == CODE_100MA) begin
        present_d = 1'b1;
        limit_d   = LIMIT_100MA;
        kind_d    = KIND_SDP;
      end
    end

    out_d.usb_supply_ok = present_d;
    out_d.usb_limit_ma  = limit_d;
    out_d.port_kind     = kind_d;
    out_d.mains_present = mains_d;
    out_d.contact_ok    = contact_d;
    out_d.busy_res      = (phase_d == PH_DCD) || (phase_d == PH_POLL);
    out_d.detect_done   = done;
    out_d.try_connect   = done && contact_d && ((kind_d == KIND_SDP) || (kind_d == KIND_CDP));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      code_q    <= CODE_NONE;
      contact_q <= 1'b0;
      present_q <= 1'b0;
      limit_q   <= '0;
      kind_q    <= KIND_SDP;
      mains_q   <= 1'b0;
    end else if (commit_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      code_q    <= code_d;
      contact_q <= contact_d;
      present_q <= present_d;
      limit_q   <= limit_d;
      kind_q    <= kind_d;
      mains_q   <= mains_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      out_q <= out_d;
    end
  end

  assign word_o = out_q;

endmodule

@@ hw/rtl/usb_charger_detect_current_limit.sv @@
// channel   dir  handshake      payload
// in_i      in   valid/ready    op, event_ma, status_byte, read_ok, dp_low, line_state
// out_o     out  valid/ready    usb_supply_ok .. try_connect, one word per input word
// apb       in   psel/penable   five config registers at byte address 4*i, pready tied high
//
// one word per cycle sustained while out_o is ready; a taken word passes the input register
// and then the result register, which sit around the update logic
// reset clears detection state and config to defaults, no clearing pass
// out_o holds its word while ready is low; the input register keeps taking words
// until both registers are full
module usb_charger_detect_current_limit #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ucd_in_if.sink                      in_i,
  ucd_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ucd_pkg::APB_AW-1:0]  paddr,
  input  logic [ucd_pkg::APB_DW-1:0]  pwdata,
  output logic [ucd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import ucd_pkg::*;

  cfg_t      cfg;
  in_word_t  s1_word_q;
  out_word_t res_word;
  logic      s1_valid_q, s1_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  logic      adv;
  logic      in_fire;

  assign out_free    = !out_valid_q || out_o.ready;
  assign adv         = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || adv;
  assign in_fire     = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_fire || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q.op          <= in_i.op;
      s1_word_q.event_ma    <= in_i.event_ma;
      s1_word_q.status_byte <= in_i.status_byte;
      s1_word_q.read_ok     <= in_i.read_ok;
      s1_word_q.dp_low      <= in_i.dp_low;
      s1_word_q.line_state  <= in_i.line_state;
    end
  end

  ucd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  ucd_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (adv),
    .word_i   (s1_word_q),
    .cfg_i    (cfg),
    .word_o   (res_word)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.usb_supply_ok = res_word.usb_supply_ok;
  assign out_o.usb_limit_ma  = res_word.usb_limit_ma;
  assign out_o.port_kind     = res_word.port_kind;
  assign out_o.mains_present = res_word.mains_present;
  assign out_o.contact_ok    = res_word.contact_ok;
  assign out_o.busy_res      = res_word.busy_res;
  assign out_o.detect_done   = res_word.detect_done;
  assign out_o.try_connect   = res_word.try_connect;

endmodule

@@ hw/rtl/ucd_checker.sv @@
module ucd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        usb_supply_ok_i,
  input logic [9:0]                  usb_limit_ma_i,
  input logic [1:0]                  port_kind_i,
  input logic                        contact_ok_i,
  input logic                        busy_res_i,
  input logic                        detect_done_i,
  input logic                        try_connect_i,
  input logic                        psel_i,
  input logic                        penable_i,
  input logic                        pwrite_i,
  input logic [ucd_pkg::APB_AW-1:0]  paddr_i,
  input logic [ucd_pkg::APB_DW-1:0]  pwdata_i,
  input logic [ucd_pkg::APB_DW-1:0]  prdata_i
);
  import ucd_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(usb_limit_ma_i) &&
      $stable(port_kind_i) && $stable(usb_supply_ok_i) && $stable(try_connect_i))
    else $error("result word changed while stalled");

  a_connect_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && try_connect_i |-> detect_done_i && contact_ok_i &&
      (port_kind_i != KIND_DCP))
    else $error("try_connect without finished detection on a data port");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && detect_done_i |-> !busy_res_i)
    else $error("detection finished but still busy");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && (paddr_i[APB_AW-1:2] == REG_DCD_TIMEOUT) |=>
      (paddr_i[APB_AW-1:2] != REG_DCD_TIMEOUT) ||
      (prdata_i == {{(APB_DW-TMO_W){1'b0}}, $past(pwdata_i[TMO_W-1:0])}))
    else $error("dcd timeout register reads back wrong value");

endmodule

bind usb_charger_detect_current_limit ucd_checker u_ucd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .usb_supply_ok_i (out_o.usb_supply_ok),
  .usb_limit_ma_i  (out_o.usb_limit_ma),
  .port_kind_i     (out_o.port_kind),
  .contact_ok_i    (out_o.contact_ok),
  .busy_res_i      (out_o.busy_res),
  .detect_done_i   (out_o.detect_done),
  .try_connect_i   (out_o.try_connect),
  .psel_i          (psel),
  .penable_i       (penable),
  .pwrite_i        (pwrite),
  .paddr_i         (paddr),
  .pwdata_i        (pwdata),
  .prdata_i        (prdata)
);

@@ tb/usb_charger_detect_current_limit_tb.sv @@
module usb_charger_detect_current_limit_tb;
  import ucd_pkg::*;

  localparam int TMR_BITS = 12;
  localparam logic [TMR_BITS-1:0] TMR_MAX = '1;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_WORDS = 90;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DCD,
    PH_POLL
  } det_phase_e;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  ucd_in_if  in_if ();
  ucd_out_if out_if ();

  usb_charger_detect_current_limit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // charger state as the block should hold it
  cfg_t cfg = '{RST_DCD_TIMEOUT, RST_POLL_TIMEOUT, RST_CDP_ENUM, RST_CDP_SUSPEND,
                RST_SDP_SUSPEND};
  det_phase_e det_phase = PH_IDLE;
  logic [TMR_BITS-1:0] tmr_cnt = '0;
  logic [1:0] code_q = CODE_NONE;
  logic contact_q = 1'b0;
  logic present_q = 1'b0;
  logic [MA_W-1:0] limit_q = '0;
  logic [1:0] kind_q = KIND_SDP;
  logic mains_q = 1'b0;

  out_word_t status_q[$];
  dir_row_t dir_rows[$];

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int detections = 0;
  int reg_writes = 0;
  int src_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int holds_done = 0;

  function automatic bit timer_expired(logic [TMO_W-1:0] lim);
    if (tmr_cnt < TMR_MAX) tmr_cnt++;
    return (tmr_cnt > lim) || (tmr_cnt >= TMR_MAX);
  endfunction

  function automatic void classify_port(logic [1:0] line);
    if (code_q == CODE_500MA) begin
      present_q = 1'b1;
      limit_q = LIMIT_500MA;
      kind_q = (line != LINE_DCP) ? KIND_CDP : KIND_DCP;
    end else if (code_q == CODE_100MA) begin
      present_q = 1'b1;
      limit_q = LIMIT_100MA;
      kind_q = KIND_SDP;
    end
    det_phase = PH_IDLE;
    tmr_cnt = '0;
  endfunction

  function automatic out_word_t charger_step(in_word_t w);
    out_word_t r;
    bit busy;
    bit done;
    busy = (det_phase != PH_IDLE);
    done = 1'b0;
    case (op_e'(w.op))
      OP_TICK: begin
        if (det_phase == PH_DCD) begin
          if (timer_expired(cfg.dcd_timeout_ms)) begin
            contact_q = 1'b0;
            det_phase = PH_POLL;
            tmr_cnt = '0;
          end
        end else if (det_phase == PH_POLL) begin
          if (timer_expired(cfg.poll_timeout_ms)) begin
            classify_port(w.line_state);
            done = 1'b1;
          end
        end
      end
      OP_DETACH: begin
        det_phase = PH_IDLE;
        tmr_cnt = '0;
        present_q = 1'b0;
        limit_q = '0;
        contact_q = 1'b0;
        kind_q = KIND_SDP;
      end
      OP_VBUS: begin
        if (!busy) begin
          det_phase = PH_DCD;
          tmr_cnt = '0;
          code_q = CODE_NONE;
          contact_q = 1'b0;
        end
      end
      OP_ENUM: begin
        if (!busy && w.event_ma != '0) begin
          present_q = 1'b1;
          limit_q = (kind_q == KIND_CDP) ? cfg.cdp_enum_ma : w.event_ma;
        end
      end
      OP_SUSPEND: begin
        if (!busy) begin
          present_q = 1'b1;
          limit_q = (kind_q == KIND_CDP) ? cfg.cdp_suspend_ma : cfg.sdp_suspend_ma;
        end
      end
      OP_RESUME: begin
        if (!busy) begin
          present_q = 1'b1;
          limit_q = (kind_q == KIND_CDP) ? cfg.cdp_suspend_ma : w.event_ma;
        end
      end
      OP_SAMPLE: begin
        if (det_phase == PH_DCD) begin
          if (!w.read_ok || w.dp_low) begin
            contact_q = w.read_ok;
            det_phase = PH_POLL;
            tmr_cnt = '0;
          end
        end else if (det_phase == PH_POLL) begin
          if (w.read_ok && w.status_byte != STS_INVALID && w.status_byte[STS_BATT_BIT]
              && w.status_byte[STS_USB_BIT]) begin
            code_q = w.status_byte[1:0];
          end else begin
            code_q = CODE_NONE;
          end
          if (code_q == CODE_500MA || !contact_q) begin
            classify_port(w.line_state);
            done = 1'b1;
          end
        end
      end
      default: begin
        mains_q = w.read_ok && w.status_byte != STS_INVALID && w.status_byte[STS_MAINS_BIT];
      end
    endcase
    r.usb_supply_ok = present_q;
    r.usb_limit_ma = limit_q;
    r.port_kind = kind_q;
    r.mains_present = mains_q;
    r.contact_ok = contact_q;
    r.busy_res = (det_phase != PH_IDLE);
    r.detect_done = done;
    r.try_connect = done && contact_q && (kind_q == KIND_SDP || kind_q == KIND_CDP);
    return r;
  endfunction

  function automatic out_word_t outw(bit p, int lim, logic [1:0] kind, bit mains, bit c,
                                     bit b, bit d, bit t);
    out_word_t r;
    r.usb_supply_ok = p;
    r.usb_limit_ma = lim[MA_W-1:0];
    r.port_kind = kind;
    r.mains_present = mains;
    r.contact_ok = c;
    r.busy_res = b;
    r.detect_done = d;
    r.try_connect = t;
    return r;
  endfunction

  function automatic void add_row(op_e op, int ma, int sts, bit ok, bit dpl, int line,
                                  bit typed, out_word_t res);
    dir_row_t row;
    row.w.op = op;
    row.w.event_ma = ma[MA_W-1:0];
    row.w.status_byte = sts[7:0];
    row.w.read_ok = ok;
    row.w.dp_low = dpl;
    row.w.line_state = line[1:0];
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  // biased toward the sequence a real attach goes through
  function automatic in_word_t rand_word();
    in_word_t w;
    int unsigned pick;
    w.op = OP_TICK;
    w.event_ma = MA_W'($urandom_range(0, 1023));
    w.status_byte = 8'($urandom_range(0, 255));
    w.read_ok = ($urandom_range(0, 9) != 0);
    w.dp_low = ($urandom_range(0, 3) == 0);
    w.line_state = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    case (det_phase)
      PH_IDLE: begin
        if (pick < 30) w.op = OP_VBUS;
        else if (pick < 45) w.op = OP_ENUM;
        else if (pick < 57) w.op = OP_SUSPEND;
        else if (pick < 69) w.op = OP_RESUME;
        else if (pick < 79) w.op = OP_MAINS;
        else if (pick < 85) w.op = OP_DETACH;
        else if (pick < 92) w.op = OP_TICK;
        else w.op = OP_SAMPLE;
        if (w.op == OP_ENUM && $urandom_range(0, 6) == 0) w.event_ma = '0;
      end
      PH_DCD: begin
        if (pick < 45) w.op = OP_TICK;
        else if (pick < 85) w.op = OP_SAMPLE;
        else w.op = 3'($urandom_range(0, 7));
      end
      default: begin
        if (pick < 35) w.op = OP_TICK;
        else if (pick < 85) w.op = OP_SAMPLE;
        else w.op = 3'($urandom_range(0, 7));
        if (w.op == OP_SAMPLE && $urandom_range(0, 99) < 65) begin
          w.status_byte = w.status_byte | 8'h14;
        end
      end
    endcase
    return w;
  endfunction

  task automatic put_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= w.op;
    in_if.event_ma <= w.event_ma;
    in_if.status_byte <= w.status_byte;
    in_if.read_ok <= w.read_ok;
    in_if.dp_low <= w.dp_low;
    in_if.line_state <= w.line_state;
    do @(posedge clk_i); while (!in_if.ready);
    pred = charger_step(w);
    status_q.push_back(typed ? typed_res : pred);
    words_sent++;
    if (pred.detect_done) detections++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DCD_TIMEOUT:  cfg.dcd_timeout_ms = val[TMO_W-1:0];
      REG_POLL_TIMEOUT: cfg.poll_timeout_ms = val[TMO_W-1:0];
      REG_CDP_ENUM:     cfg.cdp_enum_ma = val[MA_W-1:0];
      REG_CDP_SUSPEND:  cfg.cdp_suspend_ma = val[MA_W-1:0];
      REG_SDP_SUSPEND:  cfg.sdp_suspend_ma = val[MA_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic [31:0] dcd, input logic [31:0] poll,
                            input logic [31:0] cdp_enum, input logic [31:0] cdp_sus,
                            input logic [31:0] sdp_sus);
    write_reg(REG_DCD_TIMEOUT, dcd);
    write_reg(REG_POLL_TIMEOUT, poll);
    write_reg(REG_CDP_ENUM, cdp_enum);
    write_reg(REG_CDP_SUSPEND, cdp_sus);
    write_reg(REG_SDP_SUSPEND, sdp_sus);
  endtask

  task automatic finish_phase();
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int n);
    repeat (n) put_word(rand_word(), 1'b0, '0);
  endtask

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none got limit %0d", $time,
                 out_if.usb_limit_ma);
        errors++;
      end else begin
        want = status_q.pop_front();
        cmp_field("usb_supply_ok", want.usb_supply_ok, out_if.usb_supply_ok);
        cmp_field("usb_limit_ma", want.usb_limit_ma, out_if.usb_limit_ma);
        cmp_field("port_kind", want.port_kind, out_if.port_kind);
        cmp_field("mains_present", want.mains_present, out_if.mains_present);
        cmp_field("contact_ok", want.contact_ok, out_if.contact_ok);
        cmp_field("busy_res", want.busy_res, out_if.busy_res);
        cmp_field("detect_done", want.detect_done, out_if.detect_done);
        cmp_field("try_connect", want.try_connect, out_if.try_connect);
        words_checked++;
      end
    end
  end

  // result side, with an occasional long hold-off
  initial begin : result_ready
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_if.ready <= 1'b0;
          @(posedge clk_i);
        end
        holds_done++;
      end
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin : watchdog
    #3000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    in_word_t w;
    in_if.valid = 1'b0;
    in_if.op = OP_TICK;
    in_if.event_ma = '0;
    in_if.status_byte = '0;
    in_if.read_ok = 1'b0;
    in_if.dp_low = 1'b0;
    in_if.line_state = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, default registers
    add_row(OP_TICK,      0, 8'h00, 0, 0, 0, 1, outw(0, 0, KIND_SDP, 0, 0, 0, 0, 0));
    add_row(OP_SAMPLE,    0, 8'hff, 1, 1, 3, 1, outw(0, 0, KIND_SDP, 0, 0, 0, 0, 0));
    add_row(OP_ENUM,      0, 8'h00, 1, 0, 0, 1, outw(0, 0, KIND_SDP, 0, 0, 0, 0, 0));
    add_row(OP_ENUM,   1023, 8'h00, 1, 0, 0, 1, outw(1, 1023, KIND_SDP, 0, 0, 0, 0, 0));
    add_row(OP_SUSPEND,   0, 8'h00, 1, 0, 0, 1, outw(1, 2, KIND_SDP, 0, 0, 0, 0, 0));
    add_row(OP_RESUME,  777, 8'h00, 1, 0, 0, 1, outw(1, 777, KIND_SDP, 0, 0, 0, 0, 0));
    add_row(OP_MAINS,     0, 8'h08, 1, 0, 0, 1, outw(1, 777, KIND_SDP, 1, 0, 0, 0, 0));
    add_row(OP_MAINS,     0, 8'haa, 1, 0, 0, 1, outw(1, 777, KIND_SDP, 0, 0, 0, 0, 0));
    add_row(OP_MAINS,     0, 8'hff, 1, 0, 0, 1, outw(1, 777, KIND_SDP, 1, 0, 0, 0, 0));
    add_row(OP_DETACH,    0, 8'h00, 1, 0, 0, 1, outw(0, 0, KIND_SDP, 1, 0, 0, 0, 0));
    add_row(OP_VBUS,      0, 8'h00, 1, 0, 0, 1, outw(0, 0, KIND_SDP, 1, 0, 1, 0, 0));
    add_row(OP_ENUM,     50, 8'h00, 1, 0, 0, 1, outw(0, 0, KIND_SDP, 1, 0, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h00, 1, 0, 0, 1, outw(0, 0, KIND_SDP, 1, 0, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h00, 1, 1, 0, 1, outw(0, 0, KIND_SDP, 1, 1, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'haa, 1, 0, 0, 1, outw(0, 0, KIND_SDP, 1, 1, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h06, 1, 0, 0, 1, outw(0, 0, KIND_SDP, 1, 1, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h15, 0, 0, 0, 1, outw(0, 0, KIND_SDP, 1, 1, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h16, 1, 0, 0, 1, outw(1, 500, KIND_CDP, 1, 1, 0, 1, 1));
    add_row(OP_ENUM,     10, 8'h00, 1, 0, 0, 1, outw(1, 900, KIND_CDP, 1, 1, 0, 0, 0));
    add_row(OP_VBUS,      0, 8'h00, 1, 0, 0, 1, outw(1, 900, KIND_CDP, 1, 0, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h00, 0, 0, 0, 1, outw(1, 900, KIND_CDP, 1, 0, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h15, 1, 0, 3, 1, outw(1, 100, KIND_SDP, 1, 0, 0, 1, 0));
    add_row(OP_VBUS,      0, 8'h00, 1, 0, 0, 1, outw(1, 100, KIND_SDP, 1, 0, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h00, 1, 1, 0, 1, outw(1, 100, KIND_SDP, 1, 1, 1, 0, 0));
    add_row(OP_SAMPLE,    0, 8'h1e, 1, 0, 3, 1, outw(1, 500, KIND_DCP, 1, 1, 0, 1, 0));
    add_row(OP_SUSPEND,   0, 8'h00, 1, 0, 0, 0, '0);
    add_row(OP_MAINS,     0, 8'hff, 0, 0, 0, 0, '0);
    foreach (dir_rows[i]) put_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    finish_phase();

    // all registers at zero, sender mostly idle
    set_config(0, 0, 0, 0, 0);
    src_idle_pct = 86;
    stall_pct = 0;
    send_random(RAND_WORDS);
    finish_phase();

    // all registers at max, long timeouts
    set_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    src_idle_pct = 0;
    w = rand_word();
    w.op = OP_DETACH;
    put_word(w, 1'b0, '0);
    w.op = OP_VBUS;
    put_word(w, 1'b0, '0);
    repeat (20) begin
      w = rand_word();
      w.op = OP_TICK;
      put_word(w, 1'b0, '0);
    end
    stall_pct = 86;
    send_random(RAND_WORDS);
    finish_phase();

    // short timeouts, both sides idling
    set_config($urandom_range(0, 12), $urandom_range(0, 12), $urandom, $urandom, $urandom);
    src_idle_pct = 24;
    stall_pct = 24;
    send_random(RAND_WORDS);
    finish_phase();

    // long receiver hold-off while words keep coming
    set_config($urandom_range(0, 30) | ($urandom & 32'hffff_f000), $urandom_range(0, 30),
               $urandom, $urandom, $urandom);
    src_idle_pct = 0;
    stall_pct = 0;
    hold_reqs++;
    send_random(RAND_WORDS);
    finish_phase();

    set_config($urandom_range(0, 6), $urandom_range(0, 40), $urandom, $urandom, $urandom);
    send_random(RAND_WORDS);
    finish_phase();

    repeat (8) @(posedge clk_i);
    $display("run covered %0d input words and %0d checked results", words_sent,
             words_checked);
    $display("%0d detections finished, %0d register writes", detections, reg_writes);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ usb_charger_detect_current_limit.f @@
hw/rtl/ucd_pkg.sv
hw/rtl/ucd_if.sv
hw/rtl/ucd_cfg.sv
hw/rtl/ucd_core.sv
hw/rtl/usb_charger_detect_current_limit.sv
hw/rtl/ucd_checker.sv
tb/usb_charger_detect_current_limit_tb.sv
